FILE: design/euler_to_quaternion_core_defines.svh
// assertion macros used by the top-level core design file
`ifndef EULER_TO_QUATERNION_CORE_DEFINES_SVH
`define EULER_TO_QUATERNION_CORE_DEFINES_SVH

// implication checked while out of reset
`define E2Q_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked while out of reset
`define E2Q_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked also through reset
`define E2Q_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/e2q_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package e2q_pkg;

  localparam int MaxSteps = 24;

  localparam logic signed [33:0] AngPi     = 34'sd3373259426;
  localparam logic signed [33:0] AngHalfPi = 34'sd1686629713;
  localparam logic signed [32:0] GainInv   = 33'sd652032874;
  localparam logic signed [18:0] Q14One    = 19'sd16384;

  typedef logic signed [31:0] trig_t;
  typedef logic signed [15:0] quat_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:  val = 32'h3243F6A8;
      5'd1:  val = 32'h1DAC6705;
      5'd2:  val = 32'h0FADBAFC;
      5'd3:  val = 32'h07F56EA6;
      5'd4:  val = 32'h03FEAB76;
      5'd5:  val = 32'h01FFD55B;
      5'd6:  val = 32'h00FFFAAA;
      5'd7:  val = 32'h007FFF55;
      5'd8:  val = 32'h003FFFEA;
      5'd9:  val = 32'h001FFFFD;
      5'd10: val = 32'h000FFFFF;
      5'd11: val = 32'h0007FFFF;
      5'd12: val = 32'h0003FFFF;
      5'd13: val = 32'h0001FFFF;
      5'd14: val = 32'h0000FFFF;
      5'd15: val = 32'h00007FFF;
      5'd16: val = 32'h00003FFF;
      5'd17: val = 32'h00001FFF;
      5'd18: val = 32'h00000FFF;
      5'd19: val = 32'h000007FF;
      5'd20: val = 32'h000003FF;
      5'd21: val = 32'h000001FF;
      5'd22: val = 32'h000000FF;
      5'd23: val = 32'h0000007F;
      default: val = 32'h0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: design/euler_to_quaternion_core.sv
// throughput: one request per cycle while not stalled, fully pipelined
// a stalled result freezes the whole pipeline, nothing is dropped
// reset (rst_n low, synchronous) clears only the stage valid bits
`timescale 1ns / 1ps
`default_nettype none
`include "euler_to_quaternion_core_defines.svh"

module euler_to_quaternion_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic signed [15:0] in_roll,
  input  wire logic signed [15:0] in_pitch,
  input  wire logic signed [15:0] in_yaw,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic signed [15:0] out_quat_w,
  output      logic signed [15:0] out_quat_x,
  output      logic signed [15:0] out_quat_y,
  output      logic signed [15:0] out_quat_z
);

  localparam int Steps = (CORDIC_STEPS < 1) ? 1 :
                         (CORDIC_STEPS > e2q_pkg::MaxSteps) ? e2q_pkg::MaxSteps :
                         CORDIC_STEPS;
  localparam int Lat = Steps + 5;

  logic           pipe_en;
  logic [Lat-1:0] vld_r, vld_nxt;

  e2q_pkg::trig_t sr, cr, sp, cp, sy, cy;

  assign pipe_en  = !(vld_r[Lat-1] && out_stall);
  assign in_stall = !pipe_en;
  assign vld_nxt  = {vld_r[Lat-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= vld_nxt;
    end
  end

  e2q_cordic #(.STEPS(Steps)) u_roll (
    .clk(clk), .en(pipe_en), .angle(in_roll), .sin_out(sr), .cos_out(cr)
  );
  e2q_cordic #(.STEPS(Steps)) u_pitch (
    .clk(clk), .en(pipe_en), .angle(in_pitch), .sin_out(sp), .cos_out(cp)
  );
  e2q_cordic #(.STEPS(Steps)) u_yaw (
    .clk(clk), .en(pipe_en), .angle(in_yaw), .sin_out(sy), .cos_out(cy)
  );

  e2q_combine u_combine (
    .clk(clk), .en(pipe_en),
    .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
    .quat_w(out_quat_w), .quat_x(out_quat_x),
    .quat_y(out_quat_y), .quat_z(out_quat_z)
  );

  assign out_valid = vld_r[Lat-1];

  `E2Q_ASSERT_RST(a_reset_clears, clk, !rst_n, vld_r == '0)
  `E2Q_ASSERT_NXT(a_freeze_holds, clk, rst_n, !pipe_en, $stable(vld_r))
  `E2Q_ASSERT_IMP(a_w_range, clk, rst_n, out_valid,
                  out_quat_w <= 16'sd16384 && out_quat_w >= -16'sd16384)
  `E2Q_ASSERT_IMP(a_x_range, clk, rst_n, out_valid,
                  out_quat_x <= 16'sd16384 && out_quat_x >= -16'sd16384)

endmodule

`default_nettype wire

FILE: design/e2q_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module e2q_cordic #(
  parameter int STEPS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [15:0]   angle,
  output e2q_pkg::trig_t            sin_out,
  output e2q_pkg::trig_t            cos_out
);

  logic signed [32:0] x_r [0:STEPS];
  logic signed [32:0] y_r [0:STEPS];
  logic signed [32:0] z_r [0:STEPS];
  logic               flip_r [0:STEPS];
  e2q_pkg::trig_t     sin_r, cos_r;

  logic signed [33:0] half_ang;
  logic signed [33:0] fold_nxt;
  logic               flip_nxt;

  // half angle in q.30, folded into the cordic range
  always_comb begin
    half_ang = {angle[15], angle, 17'b0};
    fold_nxt = half_ang;
    flip_nxt = 1'b0;
    if (half_ang > e2q_pkg::AngHalfPi) begin
      fold_nxt = half_ang - e2q_pkg::AngPi;
      flip_nxt = 1'b1;
    end else if (half_ang < -e2q_pkg::AngHalfPi) begin
      fold_nxt = half_ang + e2q_pkg::AngPi;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= e2q_pkg::GainInv;
      y_r[0]    <= '0;
      z_r[0]    <= fold_nxt[32:0];
      flip_r[0] <= flip_nxt;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic signed [32:0] dx, dy, ang;
    logic signed [32:0] x_nxt, y_nxt, z_nxt;

    always_comb begin
      dx  = y_r[k] >>> k;
      dy  = x_r[k] >>> k;
      ang = {1'b0, e2q_pkg::atan_q30(5'(k))};
      if (!z_r[k][32]) begin
        x_nxt = x_r[k] - dx;
        y_nxt = y_r[k] + dy;
        z_nxt = z_r[k] - ang;
      end else begin
        x_nxt = x_r[k] + dx;
        y_nxt = y_r[k] - dy;
        z_nxt = z_r[k] + ang;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k+1]    <= x_nxt;
        y_r[k+1]    <= y_nxt;
        z_r[k+1]    <= z_nxt;
        flip_r[k+1] <= flip_r[k];
      end
    end
  end

  logic signed [32:0] sin_nxt, cos_nxt;

  always_comb begin
    sin_nxt = flip_r[STEPS] ? -y_r[STEPS] : y_r[STEPS];
    cos_nxt = flip_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt[31:0];
      cos_r <= cos_nxt[31:0];
    end
  end

  assign sin_out = sin_r;
  assign cos_out = cos_r;

endmodule

`default_nettype wire

FILE: design/e2q_combine.sv
`timescale 1ns / 1ps
`default_nettype none

module e2q_combine (
  input  wire logic           clk,
  input  wire logic           en,
  input  e2q_pkg::trig_t      sr,
  input  e2q_pkg::trig_t      cr,
  input  e2q_pkg::trig_t      sp,
  input  e2q_pkg::trig_t      cp,
  input  e2q_pkg::trig_t      sy,
  input  e2q_pkg::trig_t      cy,
  output e2q_pkg::quat_t      quat_w,
  output e2q_pkg::quat_t      quat_x,
  output e2q_pkg::quat_t      quat_y,
  output e2q_pkg::quat_t      quat_z
);

  function automatic e2q_pkg::quat_t to_q14(input logic signed [63:0] a,
                                            input logic signed [63:0] b,
                                            input logic               sub);
    logic signed [64:0] sum;
    logic signed [18:0] v;
    logic signed [15:0] res;
    sum = sub ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
    sum = sum + (65'sd1 <<< 45);
    v   = sum[64:46];
    if (v > e2q_pkg::Q14One) begin
      res = 16'sd16384;
    end else if (v < -e2q_pkg::Q14One) begin
      res = -16'sd16384;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  // pair products, floored to q.30
  logic signed [63:0] crcp, srsp, srcp, crsp;
  e2q_pkg::trig_t     crcp_r, srsp_r, srcp_r, crsp_r;
  e2q_pkg::trig_t     cy_r, sy_r;

  assign crcp = cr * cp;
  assign srsp = sr * sp;
  assign srcp = sr * cp;
  assign crsp = cr * sp;

  always_ff @(posedge clk) begin
    if (en) begin
      crcp_r <= crcp[61:30];
      srsp_r <= srsp[61:30];
      srcp_r <= srcp[61:30];
      crsp_r <= crsp[61:30];
      cy_r   <= cy;
      sy_r   <= sy;
    end
  end

  // triple products in q.60
  logic signed [63:0] w_a_r, w_b_r, x_a_r, x_b_r, y_a_r, y_b_r, z_a_r, z_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      w_a_r <= crcp_r * cy_r;
      w_b_r <= srsp_r * sy_r;
      x_a_r <= srcp_r * cy_r;
      x_b_r <= crsp_r * sy_r;
      y_a_r <= crsp_r * cy_r;
      y_b_r <= srcp_r * sy_r;
      z_a_r <= crcp_r * sy_r;
      z_b_r <= srsp_r * cy_r;
    end
  end

  e2q_pkg::quat_t w_r, x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= to_q14(w_a_r, w_b_r, 1'b0);
      x_r <= to_q14(x_a_r, x_b_r, 1'b1);
      y_r <= to_q14(y_a_r, y_b_r, 1'b0);
      z_r <= to_q14(z_a_r, z_b_r, 1'b1);
    end
  end

  assign quat_w = w_r;
  assign quat_x = x_r;
  assign quat_y = y_r;
  assign quat_z = z_r;

endmodule

`default_nettype wire
